@@ design/svb_pkg.sv @@
// ----------------------------------------------------------------------------
// svb_pkg
// shared types, constants and the saturation helper of the skinned vertex bounds block
// ----------------------------------------------------------------------------
package svb_pkg;
    localparam int BONES      = 128;
    localparam int INFLUENCES = 4;
    localparam int SLOTS      = (INFLUENCES < 4) ? INFLUENCES : 4;
    localparam int MAT_ELEMS  = 12;
    localparam int BONE_W     = (BONES > 1) ? $clog2(BONES) : 1;
    localparam int ADDR_W     = $clog2(BONES * MAT_ELEMS);
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_VERTEX = 1'b1;
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_BOX    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_SUM,
        ST_OUT_V,
        ST_OUT_B
    } state_t;

    typedef struct packed {
        logic                    kind;
        logic signed [31:0]      x;
        logic signed [31:0]      y;
        logic signed [31:0]      z;
        logic [30:0]             ex;
        logic [30:0]             ey;
        logic [30:0]             ez;
        logic                    last;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) return S32_MAX;
        if (v < -64'sh0000_0000_8000_0000) return S32_MIN;
        return v[31:0];
    endfunction
endpackage

@@ design/svb_lane.sv @@
// ----------------------------------------------------------------------------
// svb_lane
// one influence: a bone matrix store and the row transform of one bone
// ----------------------------------------------------------------------------
module svb_lane import svb_pkg::*; (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [31:0]              wr_data,
    input  logic [ADDR_W-1:0]        rd_base,
    input  logic [3:0]               rd_elem,
    input  logic                     mac_en,
    input  logic                     row_en,
    input  logic [1:0]               row_sel,
    input  logic                     pk_sel_en,
    input  logic [1:0]               k_sel,
    input  logic signed [31:0]       pos_x,
    input  logic signed [31:0]       pos_y,
    input  logic signed [31:0]       pos_z,
    input  logic [15:0]              weight,
    input  logic                     use_lane,
    output logic signed [32:0]       contrib_x,
    output logic signed [32:0]       contrib_y,
    output logic signed [32:0]       contrib_z
);
    logic [31:0] mem [BONES*MAT_ELEMS];
    logic signed [31:0] rd_reg;
    logic signed [63:0] prod_reg;
    logic signed [49:0] sum_reg;
    logic signed [49:0] row_sum;
    logic signed [31:0] sat_v;
    logic signed [47:0] wprod;
    logic signed [32:0] cx_reg, cy_reg, cz_reg;
    logic signed [31:0] p_k;
    logic [ADDR_W-1:0] rd_addr;

    assign rd_addr = ADDR_W'(rd_base + ADDR_W'(rd_elem));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    always_comb begin
        case (k_sel)
            2'd0:    p_k = pos_x;
            2'd1:    p_k = pos_y;
            default: p_k = pos_z;
        endcase
    end

    // element stream per row: m0,m1,m2 multiply, m3 translation
    // the row sum is cleared whenever the lane is idle and as each row closes
    always_ff @(posedge aclk) begin
        if (pk_sel_en) begin
            prod_reg <= rd_reg * p_k;
        end
        if (mac_en) begin
            sum_reg <= sum_reg + 50'(prod_reg >>> 16);
        end
        if (row_en || !(mac_en || pk_sel_en)) begin
            sum_reg <= '0;
        end
    end

    // third product and translation join the row sum as the row closes
    assign row_sum = sum_reg + 50'(prod_reg >>> 16) + 50'(rd_reg);
    assign sat_v   = sat32(64'(row_sum));
    assign wprod   = sat_v * $signed({1'b0, weight});

    always_ff @(posedge aclk) begin
        if (row_en) begin
            case (row_sel)
                2'd0:    cx_reg <= use_lane ? 33'(wprod >>> 15) : '0;
                2'd1:    cy_reg <= use_lane ? 33'(wprod >>> 15) : '0;
                default: cz_reg <= use_lane ? 33'(wprod >>> 15) : '0;
            endcase
        end
    end

    assign contrib_x = cx_reg;
    assign contrib_y = cy_reg;
    assign contrib_z = cz_reg;
endmodule

@@ design/svb_merge.sv @@
// ----------------------------------------------------------------------------
// svb_merge
// sums lane contributions, tracks min and max, forms the box
// ----------------------------------------------------------------------------
module svb_merge import svb_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     sum_en,
    input  logic                     box_clr,
    input  logic signed [32:0]       cx [SLOTS],
    input  logic signed [32:0]       cy [SLOTS],
    input  logic signed [32:0]       cz [SLOTS],
    output result_t                  vtx,
    output result_t                  box
);
    logic signed [31:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [31:0] max_x_reg, max_y_reg, max_z_reg;
    logic signed [31:0] rx_reg, ry_reg, rz_reg;
    logic signed [34:0] ax, ay, az;
    logic signed [32:0] ctx, cty, ctz;

    always_comb begin
        ax = '0; ay = '0; az = '0;
        for (int i = 0; i < SLOTS; i++) begin
            ax = ax + 35'(cx[i]);
            ay = ay + 35'(cy[i]);
            az = az + 35'(cz[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_en) begin
            rx_reg <= sat32(64'(ax));
            ry_reg <= sat32(64'(ay));
            rz_reg <= sat32(64'(az));
        end
    end

    // trackers fold the vertex in the cycle after the sum lands
    logic fold_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_reg  <= 1'b0;
            min_x_reg <= S32_MAX; min_y_reg <= S32_MAX; min_z_reg <= S32_MAX;
            max_x_reg <= S32_MIN; max_y_reg <= S32_MIN; max_z_reg <= S32_MIN;
        end else begin
            fold_reg <= sum_en;
            if (box_clr) begin
                min_x_reg <= S32_MAX; min_y_reg <= S32_MAX; min_z_reg <= S32_MAX;
                max_x_reg <= S32_MIN; max_y_reg <= S32_MIN; max_z_reg <= S32_MIN;
            end else if (fold_reg) begin
                if (rx_reg < min_x_reg) min_x_reg <= rx_reg;
                if (ry_reg < min_y_reg) min_y_reg <= ry_reg;
                if (rz_reg < min_z_reg) min_z_reg <= rz_reg;
                if (rx_reg > max_x_reg) max_x_reg <= rx_reg;
                if (ry_reg > max_y_reg) max_y_reg <= ry_reg;
                if (rz_reg > max_z_reg) max_z_reg <= rz_reg;
            end
        end
    end

    assign ctx = (33'(max_x_reg) + 33'(min_x_reg)) >>> 1;
    assign cty = (33'(max_y_reg) + 33'(min_y_reg)) >>> 1;
    assign ctz = (33'(max_z_reg) + 33'(min_z_reg)) >>> 1;

    function automatic logic [30:0] ext(input logic signed [31:0] hi,
                                        input logic signed [32:0] c);
        logic signed [33:0] e;
        e = 34'(hi) - 34'(c);
        if (e < 0) return '0;
        if (e > 34'sh7FFF_FFFF) return 31'h7FFF_FFFF;
        return e[30:0];
    endfunction

    assign vtx = '{kind: KIND_VERTEX, x: rx_reg, y: ry_reg, z: rz_reg,
                   ex: '0, ey: '0, ez: '0, last: 1'b1};
    assign box = '{kind: KIND_BOX, x: ctx[31:0], y: cty[31:0], z: ctz[31:0],
                   ex: ext(max_x_reg, ctx), ey: ext(max_y_reg, cty),
                   ez: ext(max_z_reg, ctz), last: 1'b1};
endmodule

@@ design/skinned_vertex_bounds.sv @@
// ----------------------------------------------------------------------------
// skinned_vertex_bounds
// linear blend skinning with a running axis aligned bounding box
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  cfg       in   cfg_valid/ready    bone_count
//  s_        in   s_valid/s_ready    func, load fields, vertex fields
//  m_        out  m_valid/m_ready    kind, out xyz, extent xyz, last
//
//  a load beat is written in its accept cycle, so loads can follow back to back
//  a vertex holds the input from its accept through the reads and
//  multiply-adds (three rows of four reads per lane, all lanes in parallel),
//  the merge in ST_SUM and the vertex beat; a box beat adds the ST_OUT_B state
//  reset clears control and the trackers; the bone store is not cleared
//  m_ready low holds the result register and the input side waits
module skinned_vertex_bounds import svb_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [6:0]          s_bone_index,
    input  logic [3:0]          s_element_index,
    input  logic signed [31:0]  s_element_value,
    input  logic signed [31:0]  s_pos_x,
    input  logic signed [31:0]  s_pos_y,
    input  logic signed [31:0]  s_pos_z,
    input  logic [31:0]         s_bone_ids_packed,
    input  logic [63:0]         s_weights_packed,
    input  logic                s_last_vertex,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_kind,
    output logic signed [31:0]  m_out_x,
    output logic signed [31:0]  m_out_y,
    output logic signed [31:0]  m_out_z,
    output logic [30:0]         m_extent_x,
    output logic [30:0]         m_extent_y,
    output logic [30:0]         m_extent_z,
    output logic                m_last
);
    state_t state_reg, state_next;
    logic [7:0]  bone_count_reg;
    logic [3:0]  step_reg, step_next;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [31:0] ids_reg;
    logic [63:0] wts_reg;
    logic        lastv_reg;
    logic        accept, wr_en;
    logic [ADDR_W-1:0] wr_addr;
    result_t     vtx, box, res_reg, vtx_beat;
    logic        res_valid_reg;

    // per-step lane controls, one row of four elements takes four reads
    logic        pk_en, mac_en, row_en, sum_en, box_clr;
    logic [1:0]  k_sel, row_sel;
    logic [3:0]  rd_elem;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bone_count_reg <= '0;
        end else if (cfg_valid) begin
            bone_count_reg <= cfg_data;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign wr_en   = accept && (s_func == FUNC_LOAD) && (s_element_index < 4'(MAT_ELEMS))
                     && (32'(s_bone_index) < BONES);
    assign wr_addr = ADDR_W'(32'(s_bone_index) * MAT_ELEMS + 32'(s_element_index));

    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg <= s_pos_x; py_reg <= s_pos_y; pz_reg <= s_pos_z;
            ids_reg <= s_bone_ids_packed; wts_reg <= s_weights_packed;
            lastv_reg <= s_last_vertex;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // element 4r+k is read at step 4r+k, multiplied into prod_reg at the end
    // of step 4r+k+1; the translation and the third product close row r at
    // step 4r+4
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (accept && s_func == FUNC_VERTEX) state_next = ST_MAC;
            end
            ST_MAC: begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd13) state_next = ST_SUM;
            end
            ST_SUM:   state_next = ST_OUT_V;
            ST_OUT_V: if (!res_valid_reg || m_ready) begin
                state_next = lastv_reg ? ST_OUT_B : ST_IDLE;
            end
            ST_OUT_B: if (m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    logic [3:0] s1, s2, s3;
    always_comb begin
        s1 = step_reg - 4'd1;
        s2 = step_reg - 4'd2;
        s3 = step_reg - 4'd3;
        rd_elem = (state_reg == ST_MAC && step_reg < 4'd12) ? step_reg : 4'd0;
        k_sel   = s1[1:0];
        pk_en   = (state_reg == ST_MAC) && step_reg >= 4'd1 && step_reg <= 4'd12
                  && s1[1:0] != 2'd3;
        mac_en  = (state_reg == ST_MAC) && step_reg >= 4'd2 && step_reg <= 4'd13
                  && s2[1:0] != 2'd3;
        row_en  = (state_reg == ST_MAC) && (step_reg == 4'd4 || step_reg == 4'd8
                  || step_reg == 4'd12);
        row_sel = s3[3:2];
        sum_en  = (state_reg == ST_SUM);
        box_clr = (state_reg == ST_OUT_B) && m_ready;
    end

    logic signed [32:0] cx [SLOTS];
    logic signed [32:0] cy [SLOTS];
    logic signed [32:0] cz [SLOTS];

    for (genvar g = 0; g < SLOTS; g++) begin : g_lane
        logic [7:0] id;
        logic       use_l;
        logic [ADDR_W-1:0] base;
        assign id    = ids_reg[8*g +: 8];
        assign use_l = !id[7] && (id < bone_count_reg) && (32'(id) < BONES);
        assign base  = ADDR_W'(32'(id[BONE_W-1:0]) * MAT_ELEMS);
        svb_lane u_lane (
            .aclk      (aclk),
            .wr_en     (wr_en),
            .wr_addr   (wr_addr),
            .wr_data   (s_element_value),
            .rd_base   (base),
            .rd_elem   (rd_elem),
            .mac_en    (mac_en),
            .row_en    (row_en),
            .row_sel   (row_sel),
            .pk_sel_en (pk_en),
            .k_sel     (k_sel),
            .pos_x     (px_reg),
            .pos_y     (py_reg),
            .pos_z     (pz_reg),
            .weight    (wts_reg[16*g +: 16]),
            .use_lane  (use_l),
            .contrib_x (cx[g]),
            .contrib_y (cy[g]),
            .contrib_z (cz[g])
        );
    end

    svb_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sum_en  (sum_en),
        .box_clr (box_clr),
        .cx      (cx),
        .cy      (cy),
        .cz      (cz),
        .vtx     (vtx),
        .box     (box)
    );

    // vertex beat is not the final one when a box follows
    always_comb begin
        vtx_beat      = vtx;
        vtx_beat.last = !lastv_reg;
    end

    // output register: vertex beat loads in ST_OUT_V once the register is free, box loads in ST_OUT_B on m_ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT_V && (!res_valid_reg || m_ready)) begin
            res_valid_reg <= 1'b1;
            res_reg       <= vtx_beat;
        end else if (state_reg == ST_OUT_B && m_ready) begin
            res_valid_reg <= 1'b1;
            res_reg       <= box;
        end else if (m_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    assign m_valid    = res_valid_reg;
    assign m_kind     = res_reg.kind;
    assign m_out_x    = res_reg.x;
    assign m_out_y    = res_reg.y;
    assign m_out_z    = res_reg.z;
    assign m_extent_x = res_reg.ex;
    assign m_extent_y = res_reg.ey;
    assign m_extent_z = res_reg.ez;
    assign m_last     = res_reg.last;

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_box_after_vtx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT_B) |-> lastv_reg)
        else $error("box without last vertex");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(res_reg))
        else $error("result changed while stalled");
endmodule
